>>> design/ddrs_pkg.sv
// shared types, constants and helper functions of the display diff run serializer
`default_nettype none

package ddrs_pkg;

    // frame geometry and run rules
    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int MIN_RUN = 4;

    // frame store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = 10;

    // command codes
    localparam logic [2:0] CMD_SET        = 3'd0;
    localparam logic [2:0] CMD_CLEAR      = 3'd1;
    localparam logic [2:0] CMD_START_DIFF = 3'd2;
    localparam logic [2:0] CMD_START_FULL = 3'd3;
    localparam logic [2:0] CMD_NEXT       = 3'd4;

    // framing characters
    localparam logic [7:0] CHAR_SOH = 8'h01;
    localparam logic [7:0] CHAR_H   = 8'h48;
    localparam logic [7:0] CHAR_ETX = 8'h03;

    // character phases inside a run
    localparam logic [8:0] PH_SOH    = 9'd0;
    localparam logic [8:0] PH_H      = 9'd1;
    localparam logic [8:0] PH_COLUMN = 9'd4;
    localparam logic [8:0] PH_LENGTH = 9'd6;
    localparam logic [8:0] PH_DATA   = 9'd8;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_LOC_CHK,
        ST_LOC_CMP,
        ST_EXT_CHK,
        ST_EXT_CMP,
        ST_DATA_RD,
        ST_DATA_OUT
    } state_t;

    // access to both frame stores in one cycle
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              new_we;
        logic [7:0]        new_wdata;
        logic              sent_we;
        logic [7:0]        sent_wdata;
    } ram_req_t;

    // store address of one column byte
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [2:0] page,
                                                    input logic [7:0] col);
        int sum;
        sum = int'(page) * COLUMNS + int'(col);
        return ADDR_W'(sum);
    endfunction

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

endpackage

`default_nettype wire

>>> design/ddrs_ram.sv
// generic single port synchronous ram with registered read
`default_nettype none

module ddrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> design/ddrs_seq.sv
// command sequencer: pixel updates, run search and character stream
`default_nettype none

module ddrs_seq
    import ddrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] cmd,
    input  wire logic [6:0] pixel_x,
    input  wire logic [5:0] pixel_y,
    output ram_req_t        mem_req,
    input  wire logic [7:0] new_rd,
    input  wire logic [7:0] sent_rd,
    output logic            result_valid,
    output logic [7:0]      out_char,
    output logic            end_of_run,
    output logic            finished
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              active_reg, active_next;
    logic              full_reg, full_next;
    logic [2:0]        page_reg, page_next;
    logic [7:0]        col_reg, col_next;
    logic [7:0]        len_reg, len_next;
    logic [8:0]        phase_reg, phase_next;
    logic [ADDR_W-1:0] pix_addr_reg, pix_addr_next;
    logic [2:0]        pix_bit_reg, pix_bit_next;
    logic              pix_set_reg, pix_set_next;
    logic              valid_reg, valid_next;
    logic [7:0]        char_reg, char_next;
    logic              eor_reg, eor_next;
    logic              fin_reg, fin_next;

    logic       accept;
    logic [2:0] in_page;
    logic [8:0] run_end;
    logic [8:0] col_sum;
    logic [9:0] data_limit;
    logic [8:0] data_off;
    logic [7:0] data_col;
    logic [7:0] hdr_val;
    logic       last_page;
    logic [7:0] pix_mask;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign in_page = pixel_y[5:3];

    // derived run positions
    assign run_end    = {1'b0, col_reg} + {1'b0, len_reg};
    assign col_sum    = {1'b0, col_reg} + 9'(MIN_RUN);
    assign data_limit = {1'b0, len_reg, 1'b0} + 10'(PH_DATA);
    assign data_off   = phase_reg - PH_DATA;
    assign data_col   = col_reg + data_off[8:1];
    assign last_page  = ({1'b0, page_reg} + 4'd1) >= 4'(PAGES);
    assign pix_mask   = 8'd1 << pix_bit_reg;

    // header value for the hex phases
    always_comb
    begin
        if (phase_reg < PH_COLUMN)
        begin
            hdr_val = 8'd1 << page_reg;
        end
        else if (phase_reg < PH_LENGTH)
        begin
            hdr_val = col_reg;
        end
        else
        begin
            hdr_val = len_reg;
        end
    end

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            active_reg   <= 1'b0;
            full_reg     <= 1'b0;
            page_reg     <= '0;
            col_reg      <= '0;
            len_reg      <= '0;
            phase_reg    <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            active_reg   <= active_next;
            full_reg     <= full_next;
            page_reg     <= page_next;
            col_reg      <= col_next;
            len_reg      <= len_next;
            phase_reg    <= phase_next;
            valid_reg    <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pix_addr_reg <= pix_addr_next;
        pix_bit_reg  <= pix_bit_next;
        pix_set_reg  <= pix_set_next;
        char_reg     <= char_next;
        eor_reg      <= eor_next;
        fin_reg      <= fin_next;
    end

    // next state, store access and result beat
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        active_next   = active_reg;
        full_next     = full_reg;
        page_next     = page_reg;
        col_next      = col_reg;
        len_next      = len_reg;
        phase_next    = phase_reg;
        pix_addr_next = pix_addr_reg;
        pix_bit_next  = pix_bit_reg;
        pix_set_next  = pix_set_reg;
        valid_next    = 1'b0;
        char_next     = char_reg;
        eor_next      = eor_reg;
        fin_next      = fin_reg;

        mem_req.addr       = cell_addr(page_reg, col_reg);
        mem_req.new_we     = 1'b0;
        mem_req.new_wdata  = '0;
        mem_req.sent_we    = 1'b0;
        mem_req.sent_wdata = new_rd;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero both stores after reset
                mem_req.addr      = clr_addr_reg;
                mem_req.new_we    = 1'b1;
                mem_req.sent_we   = 1'b1;
                mem_req.sent_wdata = '0;
                clr_addr_next     = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd) inside
                        CMD_SET, CMD_CLEAR:
                        begin
                            if (!active_reg && ({1'b0, pixel_x} < 8'(COLUMNS))
                                && ({1'b0, in_page} < 4'(PAGES)))
                            begin
                                pix_addr_next = cell_addr(in_page, {1'b0, pixel_x});
                                pix_bit_next  = pixel_y[2:0];
                                pix_set_next  = (cmd == CMD_SET);
                                state_next    = ST_PIX_RD;
                            end
                        end
                        CMD_START_DIFF, CMD_START_FULL:
                        begin
                            active_next = 1'b1;
                            full_next   = (cmd == CMD_START_FULL);
                            page_next   = '0;
                            col_next    = '0;
                            len_next    = '0;
                            phase_next  = PH_SOH;
                        end
                        CMD_NEXT:
                        begin
                            if (!active_reg)
                            begin
                                valid_next = 1'b1;
                                char_next  = '0;
                                eor_next   = 1'b0;
                                fin_next   = 1'b1;
                            end
                            else if (phase_reg == PH_SOH)
                            begin
                                if (full_reg)
                                begin
                                    col_next   = '0;
                                    len_next   = 8'(COLUMNS);
                                    phase_next = PH_H;
                                    valid_next = 1'b1;
                                    char_next  = CHAR_SOH;
                                    eor_next   = 1'b0;
                                    fin_next   = 1'b0;
                                end
                                else
                                begin
                                    state_next = ST_LOC_CHK;
                                end
                            end
                            else if (phase_reg == PH_H)
                            begin
                                phase_next = phase_reg + 1'b1;
                                valid_next = 1'b1;
                                char_next  = CHAR_H;
                                eor_next   = 1'b0;
                                fin_next   = 1'b0;
                            end
                            else if (phase_reg < PH_DATA)
                            begin
                                phase_next = phase_reg + 1'b1;
                                valid_next = 1'b1;
                                char_next  = phase_reg[0] ? hex_char(hdr_val[3:0])
                                                          : hex_char(hdr_val[7:4]);
                                eor_next   = 1'b0;
                                fin_next   = 1'b0;
                            end
                            else if ({1'b0, phase_reg} < data_limit)
                            begin
                                state_next = ST_DATA_RD;
                            end
                            else
                            begin
                                // close the run and move past it
                                phase_next = PH_SOH;
                                valid_next = 1'b1;
                                char_next  = CHAR_ETX;
                                eor_next   = 1'b1;
                                fin_next   = 1'b0;
                                if (run_end >= 9'(COLUMNS))
                                begin
                                    col_next = '0;
                                    if (last_page)
                                    begin
                                        active_next = 1'b0;
                                    end
                                    else
                                    begin
                                        page_next = page_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = run_end[7:0];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PIX_RD:
            begin
                mem_req.addr = pix_addr_reg;
                state_next   = ST_PIX_WR;
            end

            ST_PIX_WR:
            begin
                // read, modify, write back one pixel
                mem_req.addr      = pix_addr_reg;
                mem_req.new_we    = 1'b1;
                mem_req.new_wdata = pix_set_reg ? (new_rd | pix_mask) : (new_rd & ~pix_mask);
                state_next        = ST_IDLE;
            end

            ST_LOC_CHK:
            begin
                // search for the first differing byte
                mem_req.addr = cell_addr(page_reg, col_reg);
                if ({1'b0, col_reg} >= 9'(COLUMNS))
                begin
                    col_next = '0;
                    if (last_page)
                    begin
                        active_next = 1'b0;
                        valid_next  = 1'b1;
                        char_next   = '0;
                        eor_next    = 1'b0;
                        fin_next    = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        page_next = page_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_LOC_CMP;
                end
            end

            ST_LOC_CMP:
            begin
                if (new_rd != sent_rd)
                begin
                    if (col_sum > 9'(COLUMNS))
                    begin
                        len_next = 8'(COLUMNS) - col_reg;
                    end
                    else
                    begin
                        len_next = 8'(MIN_RUN);
                    end
                    state_next = ST_EXT_CHK;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_LOC_CHK;
                end
            end

            ST_EXT_CHK:
            begin
                // extend the run while bytes still differ
                mem_req.addr = cell_addr(page_reg, run_end[7:0]);
                if (run_end < 9'(COLUMNS))
                begin
                    state_next = ST_EXT_CMP;
                end
                else
                begin
                    phase_next = PH_H;
                    valid_next = 1'b1;
                    char_next  = CHAR_SOH;
                    eor_next   = 1'b0;
                    fin_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            ST_EXT_CMP:
            begin
                if (new_rd != sent_rd)
                begin
                    len_next   = len_reg + 1'b1;
                    state_next = ST_EXT_CHK;
                end
                else
                begin
                    phase_next = PH_H;
                    valid_next = 1'b1;
                    char_next  = CHAR_SOH;
                    eor_next   = 1'b0;
                    fin_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            ST_DATA_RD:
            begin
                mem_req.addr = cell_addr(page_reg, data_col);
                state_next   = ST_DATA_OUT;
            end

            ST_DATA_OUT:
            begin
                // data digit, low digit updates the reference
                mem_req.addr       = cell_addr(page_reg, data_col);
                mem_req.sent_we    = phase_reg[0];
                mem_req.sent_wdata = new_rd;
                phase_next         = phase_reg + 1'b1;
                valid_next         = 1'b1;
                char_next          = phase_reg[0] ? hex_char(new_rd[3:0])
                                                  : hex_char(new_rd[7:4]);
                eor_next           = 1'b0;
                fin_next           = 1'b0;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = valid_reg;
    assign out_char     = char_reg;
    assign end_of_run   = eor_reg;
    assign finished     = fin_reg;

endmodule

`default_nettype wire

>>> design/display_diff_run_serializer.sv
// top level: frame store, reference store and command sequencer
`default_nettype none

// Commands are taken when start is high and busy is low. After reset a clearing
// pass zeroes both frame stores with busy held high. Start commands and ignored
// commands leave busy low; a pixel set or clear outside a transfer reads,
// modifies and writes back the frame store byte with busy high. A next command
// answers with one result beat on result_valid in the first cycle with busy low
// again: header and trailer characters in the cycle after the command, data
// digits after one store read (ST_DATA_RD, then ST_DATA_OUT). In diff mode the
// run search compares one byte per store read through a check and a compare
// state, so the first character of a run, or the finished beat, waits on both
// states per byte compared, a check state per page crossed or row end reached,
// and the registered beat itself. Results are shown for exactly one cycle and
// cannot be held off; the receiver must take every beat.
module display_diff_run_serializer
    import ddrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] cmd,
    input  wire logic [6:0] pixel_x,
    input  wire logic [5:0] pixel_y,
    output logic            result_valid,
    output logic [7:0]      out_char,
    output logic            end_of_run,
    output logic            finished
);

    ram_req_t   mem_req;
    logic [7:0] new_rd;
    logic [7:0] sent_rd;

    // sequencer
    ddrs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .mem_req      (mem_req),
        .new_rd       (new_rd),
        .sent_rd      (sent_rd),
        .result_valid (result_valid),
        .out_char     (out_char),
        .end_of_run   (end_of_run),
        .finished     (finished)
    );

    // current frame store
    ddrs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_new_frame (
        .clk   (clk),
        .we    (mem_req.new_we),
        .addr  (mem_req.addr),
        .wdata (mem_req.new_wdata),
        .rdata (new_rd)
    );

    // reference of what the display holds
    ddrs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_sent_frame (
        .clk   (clk),
        .we    (mem_req.sent_we),
        .addr  (mem_req.addr),
        .wdata (mem_req.sent_wdata),
        .rdata (sent_rd)
    );

endmodule

`default_nettype wire
